@@ rtl/ball_collision_response_core_defines.svh @@
// ----------------------------------------------------------------------------
// ball_collision_response_core_defines
// assertion macros used by the collision response rtl
// ----------------------------------------------------------------------------
`ifndef BALL_COLLISION_RESPONSE_CORE_DEFINES_SVH
`define BALL_COLLISION_RESPONSE_CORE_DEFINES_SVH

// concurrent check, quiet while reset is asserted
`define BCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a result in the next
`define BCR_ASSERT_NEXT(name, pre, post, msg) \
  `BCR_ASSERT(name, (pre) |=> (post), msg)

`endif

@@ rtl/bcr_pkg.sv @@
// ----------------------------------------------------------------------------
// bcr_pkg
// shared constants and types of the ball collision response core
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // restitution is always unsigned q1.16
  localparam logic [16:0] RESTITUTION_RESET = 17'd52429;
  localparam logic [16:0] RESTITUTION_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    OUT_IMPULSE    = 2'd0,
    OUT_SEPARATE   = 2'd1,
    OUT_COINCIDENT = 2'd2
  } outcome_e;

endpackage

`default_nettype wire

@@ rtl/ball_collision_response_core.sv @@
// Fixed point: Q16.16 at the default FRAC_BITS.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the bit-serial square root (32 stages) and the restoring
// dividers (FRAC_BITS + 2 stages), one bit per stage.
// Reset: stage valid bits clear, restitution returns to 52429 (about 0.8).
// ----------------------------------------------------------------------------
// ball_collision_response_core
// pipelined two-circle separation and restitution impulse, signed fixed point
// ----------------------------------------------------------------------------
`default_nettype none

`include "ball_collision_response_core_defines.svh"

module ball_collision_response_core #(
  parameter int FRAC_BITS = bcr_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               restitution_we_i,
  input  wire logic        [16:0] restitution_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [31:0] first_pos_x_i,
  input  wire logic signed [31:0] first_pos_y_i,
  input  wire logic signed [31:0] first_vel_x_i,
  input  wire logic signed [31:0] first_vel_y_i,
  input  wire logic        [30:0] first_radius_i,
  input  wire logic        [30:0] first_mass_i,
  input  wire logic signed [31:0] second_pos_x_i,
  input  wire logic signed [31:0] second_pos_y_i,
  input  wire logic signed [31:0] second_vel_x_i,
  input  wire logic signed [31:0] second_vel_y_i,
  input  wire logic        [30:0] second_radius_i,
  input  wire logic        [30:0] second_mass_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] new_first_pos_x_o,
  output      logic signed [31:0] new_first_pos_y_o,
  output      logic signed [31:0] new_first_vel_x_o,
  output      logic signed [31:0] new_first_vel_y_o,
  output      logic signed [31:0] new_second_pos_x_o,
  output      logic signed [31:0] new_second_pos_y_o,
  output      logic signed [31:0] new_second_vel_x_o,
  output      logic signed [31:0] new_second_vel_y_o,
  output      logic        [1:0]  outcome_o
);

  localparam int F     = FRAC_BITS;
  localparam int Q     = F + 2;           // quotient bits, also small operand width
  localparam int SM_W  = Q;
  localparam int SV_W  = 44;              // signed working width
  localparam int BIG_W = 40;              // magnitude width of the large operand
  localparam int HALF  = BIG_W / 2;
  localparam int PP_W  = HALF + SM_W;
  localparam int PR_W  = BIG_W + SM_W;
  localparam int DIV_W = 33 + Q;
  localparam int NL    = 3;               // divider lanes: nx, ny, w1
  localparam int ML    = 5;               // multiplier lanes
  localparam int SH_UP = (F >= 16) ? F - 16 : 0;
  localparam int SH_DN = (F >= 16) ? 0 : 16 - F;

  localparam int S_SQR  = 1;
  localparam int S_SUM  = 2;
  localparam int S_RT0  = 3;
  localparam int S_DIVI = S_RT0 + 32;
  localparam int S_DV0  = S_DIVI + 1;
  localparam int S_M1A  = S_DV0 + Q;
  localparam int S_M1B  = S_M1A + 1;
  localparam int S_VN   = S_M1B + 1;
  localparam int S_M2A  = S_VN + 1;
  localparam int S_M2B  = S_M2A + 1;
  localparam int S_M3A  = S_M2B + 1;
  localparam int S_M3B  = S_M3A + 1;
  localparam int S_M4A  = S_M3B + 1;
  localparam int S_M4B  = S_M4A + 1;
  localparam int S_OUT  = S_M4B + 1;
  localparam int NST    = S_OUT + 1;

  localparam logic [SM_W-1:0] ONE = SM_W'(1) << F;
  localparam logic [PR_W-1:0] RND = PR_W'(1) << (F - 1);
  localparam logic signed [SV_W-1:0] SMAX = SV_W'(32'sh7fffffff);
  localparam logic signed [SV_W-1:0] SMIN = -SMAX - SV_W'(1);

  typedef struct packed {
    logic [PP_W-1:0] lo;
    logic [PP_W-1:0] hi;
    logic            neg;
  } pp_t;

  typedef struct packed {
    logic signed [31:0]                p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic [30:0]                       r1, r2;
    logic [31:0]                       m2, msum;
    logic                              xneg, yneg, big, coin;
    logic [32:0]                       ax, ay;
    logic [63:0]                       sqx, sqy, rem, res;
    logic signed [SV_W-1:0]            pen, dvx, dvy, tx, ty, mx, my, vn, j, dv1, dv2;
    logic signed [SV_W-1:0]            a1x, a1y, a2x, a2y, f1x, f1y, f2x, f2y;
    logic [NL-1:0][DIV_W-1:0]          drem;
    logic [NL-1:0][32:0]               dden;
    logic [NL-1:0][Q-1:0]              dq;
    logic [SM_W-1:0]                   nxm, nym, w1, w2, onee;
    pp_t [ML-1:0]                      pp;
    logic [7:0][31:0]                  o;
    bcr_pkg::outcome_e                 oc;
  } ctx_t;

  // magnitude split into two partial products
  function automatic pp_t mul_a(logic signed [SV_W-1:0] a, logic [SM_W-1:0] b,
                                logic b_neg);
    logic [SV_W-1:0] m;
    pp_t             p;
    m     = a[SV_W-1] ? SV_W'(-a) : SV_W'(a);
    p.lo  = PP_W'(m[HALF-1:0]) * PP_W'(b);
    p.hi  = PP_W'(m[BIG_W-1:HALF]) * PP_W'(b);
    p.neg = a[SV_W-1] ^ b_neg;
    return p;
  endfunction

  // combine, round half away from zero, restore sign
  function automatic logic signed [SV_W-1:0] mul_b(pp_t p);
    logic [PR_W-1:0]        s;
    logic signed [SV_W-1:0] r;
    s = PR_W'(p.lo) + (PR_W'(p.hi) << HALF);
    s = (s + RND) >> F;
    r = SV_W'(s);
    return p.neg ? -r : r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [SV_W-1:0] x);
    if (x > SMAX) begin
      return 32'h7fffffff;
    end else if (x < SMIN) begin
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  logic [16:0]     restitution_q;
  logic [16:0]     e_clamp;
  logic [SM_W-1:0] e_scaled;
  logic            adv;
  logic [NST-1:0]  vld_q;
  ctx_t            cap_d;
  ctx_t            st_q [NST];
  ctx_t            st_d [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= bcr_pkg::RESTITUTION_RESET;
    end else if (restitution_we_i) begin
      restitution_q <= restitution_i;
    end
  end

  assign e_clamp  = (restitution_q > bcr_pkg::RESTITUTION_ONE) ?
                    bcr_pkg::RESTITUTION_ONE : restitution_q;
  assign e_scaled = SM_W'((25'(e_clamp) << SH_UP) >> SH_DN);

  assign adv         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NST-1];

  // capture stage: center deltas and mass sum
  always_comb begin
    logic signed [32:0] dxs;
    logic signed [32:0] dys;
    logic [31:0]        m1f;
    logic [31:0]        m2f;
    cap_d      = '0;
    cap_d.p1x  = first_pos_x_i;
    cap_d.p1y  = first_pos_y_i;
    cap_d.v1x  = first_vel_x_i;
    cap_d.v1y  = first_vel_y_i;
    cap_d.p2x  = second_pos_x_i;
    cap_d.p2y  = second_pos_y_i;
    cap_d.v2x  = second_vel_x_i;
    cap_d.v2y  = second_vel_y_i;
    cap_d.r1   = first_radius_i;
    cap_d.r2   = second_radius_i;
    dxs        = 33'(first_pos_x_i) - 33'(second_pos_x_i);
    dys        = 33'(first_pos_y_i) - 33'(second_pos_y_i);
    cap_d.xneg = dxs[32];
    cap_d.yneg = dys[32];
    cap_d.ax   = dxs[32] ? 33'(-dxs) : 33'(dxs);
    cap_d.ay   = dys[32] ? 33'(-dys) : 33'(dys);
    cap_d.big  = cap_d.ax[32] | cap_d.ax[31] | cap_d.ay[32] | cap_d.ay[31];
    // zero mass counts as one lsb
    m1f        = (first_mass_i == '0) ? 32'd1 : 32'(first_mass_i);
    m2f        = (second_mass_i == '0) ? 32'd1 : 32'(second_mass_i);
    cap_d.m2   = m2f;
    cap_d.msum = m1f + m2f;
  end

  always_comb begin
    ctx_t               c;
    ctx_t               n;
    logic [31:0]        sx;
    logic [31:0]        sy;
    logic [63:0]        bitv;
    logic [63:0]        t;
    logic [32:0]        d;
    logic [DIV_W-1:0]   sh;
    int                 it;
    st_d[0] = cap_d;
    sx      = '0;
    sy      = '0;
    bitv    = '0;
    t       = '0;
    d       = '0;
    sh      = '0;
    it      = 0;
    for (int k = 1; k < NST; k++) begin
      c = st_q[k-1];
      n = c;
      if (k == S_SQR) begin
        sx    = c.big ? c.ax[32:1] : c.ax[31:0];
        sy    = c.big ? c.ay[32:1] : c.ay[31:0];
        n.sqx = 64'(sx) * 64'(sx);
        n.sqy = 64'(sy) * 64'(sy);
      end else if (k == S_SUM) begin
        n.rem = c.sqx + c.sqy;
        n.res = '0;
      end else if (k >= S_RT0 && k < S_DIVI) begin
        // one root bit per stage
        it   = k - S_RT0;
        bitv = 64'(1) << (62 - 2 * it);
        t    = c.res + bitv;
        if (c.rem >= t) begin
          n.rem = c.rem - t;
          n.res = (c.res >> 1) + bitv;
        end else begin
          n.res = c.res >> 1;
        end
      end else if (k == S_DIVI) begin
        d         = c.big ? {c.res[31:0], 1'b0} : c.res[32:0];
        n.coin    = (d == '0);
        n.pen     = SV_W'(c.r1) + SV_W'(c.r2) - SV_W'(d);
        n.dvx     = SV_W'(c.v1x) - SV_W'(c.v2x);
        n.dvy     = SV_W'(c.v1y) - SV_W'(c.v2y);
        n.drem[0] = (DIV_W'(c.ax) << F) + DIV_W'(d >> 1);
        n.drem[1] = (DIV_W'(c.ay) << F) + DIV_W'(d >> 1);
        n.drem[2] = (DIV_W'(c.m2) << F) + DIV_W'(c.msum >> 1);
        n.dden[0] = d;
        n.dden[1] = d;
        n.dden[2] = 33'(c.msum);
        n.dq      = '0;
      end else if (k >= S_DV0 && k < S_M1A) begin
        // restoring division, msb first
        it = Q - 1 - (k - S_DV0);
        for (int l = 0; l < NL; l++) begin
          sh = DIV_W'(c.dden[l]) << it;
          if (c.drem[l] >= sh) begin
            n.drem[l] = c.drem[l] - sh;
            n.dq[l]   = c.dq[l] | (Q'(1) << it);
          end
        end
      end else if (k == S_M1A) begin
        n.nxm   = c.dq[0];
        n.nym   = c.dq[1];
        n.w1    = c.dq[2];
        n.w2    = ONE - c.dq[2];
        n.onee  = ONE + e_scaled;
        n.pp[0] = mul_a(c.pen, c.dq[0], c.xneg);
        n.pp[1] = mul_a(c.pen, c.dq[1], c.yneg);
        n.pp[2] = mul_a(c.dvx, c.dq[0], c.xneg);
        n.pp[3] = mul_a(c.dvy, c.dq[1], c.yneg);
      end else if (k == S_M1B) begin
        n.mx = mul_b(c.pp[0]);
        n.my = mul_b(c.pp[1]);
        n.tx = mul_b(c.pp[2]);
        n.ty = mul_b(c.pp[3]);
      end else if (k == S_VN) begin
        n.vn = c.tx + c.ty;
      end else if (k == S_M2A) begin
        n.pp[0] = mul_a(c.mx, c.w1, 1'b0);
        n.pp[1] = mul_a(c.my, c.w1, 1'b0);
        n.pp[2] = mul_a(c.mx, c.w2, 1'b0);
        n.pp[3] = mul_a(c.my, c.w2, 1'b0);
        n.pp[4] = mul_a(-c.vn, c.onee, 1'b0);
      end else if (k == S_M2B) begin
        n.a1x = mul_b(c.pp[0]);
        n.a1y = mul_b(c.pp[1]);
        n.a2x = mul_b(c.pp[2]);
        n.a2y = mul_b(c.pp[3]);
        n.j   = mul_b(c.pp[4]);
      end else if (k == S_M3A) begin
        n.pp[0] = mul_a(c.j, c.w1, 1'b0);
        n.pp[1] = mul_a(c.j, c.w2, 1'b0);
      end else if (k == S_M3B) begin
        n.dv1 = mul_b(c.pp[0]);
        n.dv2 = mul_b(c.pp[1]);
      end else if (k == S_M4A) begin
        n.pp[0] = mul_a(c.dv1, c.nxm, c.xneg);
        n.pp[1] = mul_a(c.dv1, c.nym, c.yneg);
        n.pp[2] = mul_a(c.dv2, c.nxm, c.xneg);
        n.pp[3] = mul_a(c.dv2, c.nym, c.yneg);
      end else if (k == S_M4B) begin
        n.f1x = mul_b(c.pp[0]);
        n.f1y = mul_b(c.pp[1]);
        n.f2x = mul_b(c.pp[2]);
        n.f2y = mul_b(c.pp[3]);
      end else if (k == S_OUT) begin
        if (c.coin) begin
          // coincident centers pass everything through
          n.o  = {c.v2y, c.v2x, c.p2y, c.p2x, c.v1y, c.v1x, c.p1y, c.p1x};
          n.oc = bcr_pkg::OUT_COINCIDENT;
        end else begin
          n.o[0] = sat32(SV_W'(c.p1x) + c.a1x);
          n.o[1] = sat32(SV_W'(c.p1y) + c.a1y);
          n.o[4] = sat32(SV_W'(c.p2x) - c.a2x);
          n.o[5] = sat32(SV_W'(c.p2y) - c.a2y);
          if (c.vn > SV_W'(0)) begin
            n.o[2] = c.v1x;
            n.o[3] = c.v1y;
            n.o[6] = c.v2x;
            n.o[7] = c.v2y;
            n.oc   = bcr_pkg::OUT_SEPARATE;
          end else begin
            n.o[2] = sat32(SV_W'(c.v1x) + c.f1x);
            n.o[3] = sat32(SV_W'(c.v1y) + c.f1y);
            n.o[6] = sat32(SV_W'(c.v2x) - c.f2x);
            n.o[7] = sat32(SV_W'(c.v2y) - c.f2y);
            n.oc   = bcr_pkg::OUT_IMPULSE;
          end
        end
      end
      st_d[k] = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign new_first_pos_x_o  = st_q[NST-1].o[0];
  assign new_first_pos_y_o  = st_q[NST-1].o[1];
  assign new_first_vel_x_o  = st_q[NST-1].o[2];
  assign new_first_vel_y_o  = st_q[NST-1].o[3];
  assign new_second_pos_x_o = st_q[NST-1].o[4];
  assign new_second_pos_y_o = st_q[NST-1].o[5];
  assign new_second_vel_x_o = st_q[NST-1].o[6];
  assign new_second_vel_y_o = st_q[NST-1].o[7];
  assign outcome_o          = st_q[NST-1].oc;

  `BCR_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0],
                   "accepted beat missing from first stage")
  `BCR_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_q), "pipeline moved during stall")
  `BCR_ASSERT(a_coin_pass,
              out_valid_o && st_q[NST-1].oc == bcr_pkg::OUT_COINCIDENT
                |-> new_first_pos_x_o == st_q[NST-1].p1x,
              "coincident beat altered position")
  `BCR_ASSERT(a_sep_keeps_vel,
              out_valid_o && st_q[NST-1].oc == bcr_pkg::OUT_SEPARATE
                |-> new_second_vel_y_o == st_q[NST-1].v2y,
              "separating beat altered velocity")

endmodule

`default_nettype wire

@@ tb/sv/ball_collision_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ball_collision_checker
// watches both channels of the collision core, predicts each result beat
// from the accepted input beat and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module ball_collision_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               restitution_we_i,
  input  wire logic        [16:0] restitution_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [31:0] first_pos_x_i,
  input  wire logic signed [31:0] first_pos_y_i,
  input  wire logic signed [31:0] first_vel_x_i,
  input  wire logic signed [31:0] first_vel_y_i,
  input  wire logic        [30:0] first_radius_i,
  input  wire logic        [30:0] first_mass_i,
  input  wire logic signed [31:0] second_pos_x_i,
  input  wire logic signed [31:0] second_pos_y_i,
  input  wire logic signed [31:0] second_vel_x_i,
  input  wire logic signed [31:0] second_vel_y_i,
  input  wire logic        [30:0] second_radius_i,
  input  wire logic        [30:0] second_mass_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] new_first_pos_x_i,
  input  wire logic signed [31:0] new_first_pos_y_i,
  input  wire logic signed [31:0] new_first_vel_x_i,
  input  wire logic signed [31:0] new_first_vel_y_i,
  input  wire logic signed [31:0] new_second_pos_x_i,
  input  wire logic signed [31:0] new_second_pos_y_i,
  input  wire logic signed [31:0] new_second_vel_x_i,
  input  wire logic signed [31:0] new_second_vel_y_i,
  input  wire logic        [1:0]  outcome_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      impulse_count_o,
  output int                      separate_count_o,
  output int                      coincident_count_o
);

  localparam int FB = bcr_pkg::FRAC_BITS_DEF;

  typedef struct {
    logic [31:0]       p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    bcr_pkg::outcome_e outcome;
  } resolved_pair_t;

  resolved_pair_t resolved_q[$];
  logic [16:0]    restitution_q;

  function automatic longint unsigned magn(longint a);
    return a < 0 ? 64'd0 - longint'(a) : longint'(a);
  endfunction

  // fixed-point product, rounded half away from zero on the magnitude
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = magn(a) * magn(b);
    p = (p + (64'd1 << (FB - 1))) >> FB;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(longint x);
    if (x > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (x < -64'sh80000000) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic resolved_pair_t resolve_pair(
    longint p1x, longint p1y, longint v1x, longint v1y, longint r1, longint unsigned m1,
    longint p2x, longint p2y, longint v2x, longint v2y, longint r2, longint unsigned m2,
    longint unsigned rest
  );
    resolved_pair_t  r;
    longint          dx, dy, nx, ny, pen, mx, my, w1, w2, vn, j, dv1, dv2;
    longint unsigned ax, ay, d, sum, e;
    dx = p1x - p2x;
    dy = p1y - p2y;
    ax = magn(dx);
    ay = magn(dy);
    // huge deltas: halve before squaring so the sum fits
    if (ax >= 64'h80000000 || ay >= 64'h80000000)
      d = int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
    else
      d = int_sqrt(ax * ax + ay * ay);
    if (d == 0) begin
      r.p1x = p1x[31:0]; r.p1y = p1y[31:0]; r.v1x = v1x[31:0]; r.v1y = v1y[31:0];
      r.p2x = p2x[31:0]; r.p2y = p2y[31:0]; r.v2x = v2x[31:0]; r.v2y = v2y[31:0];
      r.outcome = bcr_pkg::OUT_COINCIDENT;
      return r;
    end
    nx = longint'(((ax << FB) + (d >> 1)) / d);
    ny = longint'(((ay << FB) + (d >> 1)) / d);
    if (dx < 0) nx = -nx;
    if (dy < 0) ny = -ny;
    pen = r1 + r2 - longint'(d);
    mx  = fx_mul(nx, pen);
    my  = fx_mul(ny, pen);
    if (m1 == 0) m1 = 1;
    if (m2 == 0) m2 = 1;
    sum = m1 + m2;
    w1  = longint'(((m2 << FB) + (sum >> 1)) / sum);
    w2  = (longint'(1) << FB) - w1;
    r.p1x = sat32(p1x + fx_mul(mx, w1));
    r.p1y = sat32(p1y + fx_mul(my, w1));
    r.p2x = sat32(p2x - fx_mul(mx, w2));
    r.p2y = sat32(p2y - fx_mul(my, w2));
    vn = fx_mul(v1x - v2x, nx) + fx_mul(v1y - v2y, ny);
    if (vn > 0) begin
      r.v1x = v1x[31:0]; r.v1y = v1y[31:0]; r.v2x = v2x[31:0]; r.v2y = v2y[31:0];
      r.outcome = bcr_pkg::OUT_SEPARATE;
      return r;
    end
    e = rest > 65536 ? 65536 : rest;
    e = e << (FB - 16);
    j   = fx_mul((longint'(1) << FB) + longint'(e), -vn);
    dv1 = fx_mul(j, w1);
    dv2 = fx_mul(j, w2);
    r.v1x = sat32(v1x + fx_mul(nx, dv1));
    r.v1y = sat32(v1y + fx_mul(ny, dv1));
    r.v2x = sat32(v2x - fx_mul(nx, dv2));
    r.v2y = sat32(v2y - fx_mul(ny, dv2));
    r.outcome = bcr_pkg::OUT_IMPULSE;
    return r;
  endfunction

  task automatic check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, nm, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o       = 0;
    pending_o          = 0;
    impulse_count_o    = 0;
    separate_count_o   = 0;
    coincident_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    resolved_pair_t want;
    if (!rst_ni) begin
      restitution_q <= bcr_pkg::RESTITUTION_RESET;
      resolved_q.delete();
    end else begin
      if (restitution_we_i) restitution_q <= restitution_i;
      if (in_valid_i && in_ready_i)
        resolved_q.push_back(resolve_pair(
          first_pos_x_i, first_pos_y_i, first_vel_x_i, first_vel_y_i,
          longint'(first_radius_i), longint'(first_mass_i),
          second_pos_x_i, second_pos_y_i, second_vel_x_i, second_vel_y_i,
          longint'(second_radius_i), longint'(second_mass_i),
          longint'(restitution_q)));
      if (out_valid_i && out_ready_i) begin
        if (resolved_q.size() == 0) begin
          $display("%0t: result beat with none expected, actual outcome %0d",
                   $time, outcome_i);
          fail_count_o++;
        end else begin
          want = resolved_q.pop_front();
          check_field("new_first_pos_x", want.p1x, new_first_pos_x_i);
          check_field("new_first_pos_y", want.p1y, new_first_pos_y_i);
          check_field("new_first_vel_x", want.v1x, new_first_vel_x_i);
          check_field("new_first_vel_y", want.v1y, new_first_vel_y_i);
          check_field("new_second_pos_x", want.p2x, new_second_pos_x_i);
          check_field("new_second_pos_y", want.p2y, new_second_pos_y_i);
          check_field("new_second_vel_x", want.v2x, new_second_vel_x_i);
          check_field("new_second_vel_y", want.v2y, new_second_vel_y_i);
          check_field("outcome", 32'(want.outcome), 32'(outcome_i));
          case (want.outcome)
            bcr_pkg::OUT_IMPULSE:  impulse_count_o++;
            bcr_pkg::OUT_SEPARATE: separate_count_o++;
            default:               coincident_count_o++;
          endcase
        end
      end
      pending_o = resolved_q.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the collision response core: directed corner
// pairs, then random collision pairs under several idle and stall mixes and
// restitution settings; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int LATENCY = bcr_pkg::FRAC_BITS_DEF + 47;

  typedef struct {
    logic [31:0] p1x, p1y, v1x, v1y;
    logic [30:0] r1, m1;
    logic [31:0] p2x, p2y, v2x, v2y;
    logic [30:0] r2, m2;
  } ball_pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               restitution_we_i = 1'b0;
  logic        [16:0] restitution_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] first_pos_x_i = '0, first_pos_y_i = '0;
  logic signed [31:0] first_vel_x_i = '0, first_vel_y_i = '0;
  logic        [30:0] first_radius_i = '0, first_mass_i = '0;
  logic signed [31:0] second_pos_x_i = '0, second_pos_y_i = '0;
  logic signed [31:0] second_vel_x_i = '0, second_vel_y_i = '0;
  logic        [30:0] second_radius_i = '0, second_mass_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] new_first_pos_x_o, new_first_pos_y_o;
  logic signed [31:0] new_first_vel_x_o, new_first_vel_y_o;
  logic signed [31:0] new_second_pos_x_o, new_second_pos_y_o;
  logic signed [31:0] new_second_vel_x_o, new_second_vel_y_o;
  logic        [1:0]  outcome_o;

  int fail_count, pending, n_impulse, n_separate, n_coincident;
  int idle_pct  = 0;
  int stall_pct = 0;
  int beats_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ball_collision_response_core u_top (.*);

  ball_collision_checker u_checker (
    .clk_i, .rst_ni, .restitution_we_i, .restitution_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .first_pos_x_i, .first_pos_y_i, .first_vel_x_i, .first_vel_y_i,
    .first_radius_i, .first_mass_i,
    .second_pos_x_i, .second_pos_y_i, .second_vel_x_i, .second_vel_y_i,
    .second_radius_i, .second_mass_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .new_first_pos_x_i(new_first_pos_x_o), .new_first_pos_y_i(new_first_pos_y_o),
    .new_first_vel_x_i(new_first_vel_x_o), .new_first_vel_y_i(new_first_vel_y_o),
    .new_second_pos_x_i(new_second_pos_x_o), .new_second_pos_y_i(new_second_pos_y_o),
    .new_second_vel_x_i(new_second_vel_x_o), .new_second_vel_y_i(new_second_vel_y_o),
    .outcome_i(outcome_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .impulse_count_o(n_impulse), .separate_count_o(n_separate),
    .coincident_count_o(n_coincident)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  function automatic ball_pair_t mk_pair(
    logic [31:0] p1x, p1y, v1x, v1y, r1, m1,
    logic [31:0] p2x, p2y, v2x, v2y, r2, m2
  );
    ball_pair_t b;
    b.p1x = p1x; b.p1y = p1y; b.v1x = v1x; b.v1y = v1y;
    b.r1  = r1[30:0]; b.m1 = m1[30:0];
    b.p2x = p2x; b.p2y = p2y; b.v2x = v2x; b.v2y = v2y;
    b.r2  = r2[30:0]; b.m2 = m2[30:0];
    return b;
  endfunction

  function automatic logic [31:0] small_signed(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic ball_pair_t rand_pair();
    ball_pair_t b;
    int         sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      // plausible contact: nearby centers, radii on the scale of the offsets
      b.p1x = small_signed(1 << 22);
      b.p1y = small_signed(1 << 22);
      b.p2x = b.p1x + small_signed(1 << 19);
      b.p2y = b.p1y + small_signed(1 << 19);
      b.v1x = small_signed(1 << 21);
      b.v1y = small_signed(1 << 21);
      b.v2x = small_signed(1 << 21);
      b.v2y = small_signed(1 << 21);
      b.r1  = 31'($urandom_range(1 << 19));
      b.r2  = 31'($urandom_range(1 << 19));
      b.m1  = 31'($urandom_range(1 << 22));
      b.m2  = 31'($urandom_range(1 << 22));
    end else begin
      b.p1x = $urandom; b.p1y = $urandom; b.v1x = $urandom; b.v1y = $urandom;
      b.p2x = $urandom; b.p2y = $urandom; b.v2x = $urandom; b.v2y = $urandom;
      b.r1  = 31'($urandom); b.r2 = 31'($urandom);
      b.m1  = 31'($urandom); b.m2 = 31'($urandom);
      // occasionally land the centers on top of each other
      if (sel >= 95) begin
        b.p2x = b.p1x;
        b.p2y = b.p1y;
      end
    end
    return b;
  endfunction

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_pair(ball_pair_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i      <= 1'b1;
    first_pos_x_i   <= b.p1x; first_pos_y_i  <= b.p1y;
    first_vel_x_i   <= b.v1x; first_vel_y_i  <= b.v1y;
    first_radius_i  <= b.r1;  first_mass_i   <= b.m1;
    second_pos_x_i  <= b.p2x; second_pos_y_i <= b.p2y;
    second_vel_x_i  <= b.v2x; second_vel_y_i <= b.v2y;
    second_radius_i <= b.r2;  second_mass_i  <= b.m2;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_restitution(logic [16:0] v);
    restitution_we_i <= 1'b1;
    restitution_i    <= v;
    @(posedge clk_i);
    restitution_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    ball_pair_t  directed[$];
    logic [16:0] settings[4];
    int          idle_sel[4];
    int          stall_sel[4];
    settings  = '{17'd0, bcr_pkg::RESTITUTION_ONE, 17'h1FFFF, 17'd0};
    idle_sel  = '{0, 50, 0, 9};
    stall_sel = '{0, 0, 50, 9};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coincident centers, also at the extremes
    directed.push_back(mk_pair(32'h10000, 32'h20000, 32'h7FFFFFFF, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000, 32'h20000,
                               32'h0, 32'hFFFFFFFF, 32'h0, 32'h0));
    directed.push_back(mk_pair(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1,
                               32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1));
    // head-on approach, overlapping, equal masses
    directed.push_back(mk_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000,
                               32'h18000, 0, 32'hFFFF0000, 0, 32'h10000, 32'h10000));
    // moving apart: positions only
    directed.push_back(mk_pair(0, 0, 32'hFFFF0000, 0, 32'h10000, 32'h10000,
                               32'h18000, 0, 32'h10000, 0, 32'h10000, 32'h10000));
    // not overlapping: pulled together by the gap
    directed.push_back(mk_pair(0, 0, 0, 32'h8000, 32'h4000, 32'h20000,
                               32'h30000, 32'h40000, 0, 32'hFFFF8000, 32'h4000, 32'h8000));
    // zero masses count as one lsb
    directed.push_back(mk_pair(32'h5000, 32'h3000, 32'h1000, 0, 32'h20000, 0,
                               0, 0, 0, 32'h1000, 32'h20000, 0));
    directed.push_back(mk_pair(32'h5000, 32'h3000, 32'h1000, 0, 32'h20000, 0,
                               0, 0, 0, 32'h1000, 32'h20000, 32'h7FFFFFFF));
    // deltas of 2^31 and beyond take the halved square root
    directed.push_back(mk_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 1, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(mk_pair(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h80000000, 0,
                               32'h7FFFFFFF, 1));
    directed.push_back(mk_pair(0, 32'h80000000, 0, 32'hFFFFFFFF, 0, 1,
                               0, 32'h7FFFFFFF, 0, 1, 0, 1));
    // one lsb apart, big radii: saturating position push
    directed.push_back(mk_pair(32'h7FFFFFF0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 1, 32'h7FFFFFEF, 0, 32'h80000000,
                               32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(mk_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 0,
                               32'h40000000, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0,
                               32'h40000000, 1));
    // diagonal approach
    directed.push_back(mk_pair(32'h10000, 32'h10000, 32'hFFFF0000, 32'hFFFF0000,
                               32'h18000, 32'h30000, 0, 0, 32'h8000, 32'h8000,
                               32'h18000, 32'h10000));
    // touching at rest: zero normal speed still takes the impulse branch
    directed.push_back(mk_pair(32'h20000, 0, 0, 0, 32'h10000, 32'h10000,
                               0, 0, 0, 0, 32'h10000, 32'h10000));

    foreach (directed[i]) send_pair(directed[i]);
    drain();
    write_restitution(bcr_pkg::RESTITUTION_ONE);
    foreach (directed[i]) send_pair(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        write_restitution(17'($urandom_range(bcr_pkg::RESTITUTION_ONE)));
      end else begin
        write_restitution(settings[ph]);
      end
      idle_pct  = idle_sel[ph];
      stall_pct = stall_sel[ph];
      for (int n = 0; n < 125; n++) begin
        // hold off until the pipeline is empty, then resume back to back
        if (ph == 2 && n == 70) begin
          in_valid_i <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        send_pair(rand_pair());
      end
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;
    write_restitution(bcr_pkg::RESTITUTION_RESET);
    for (int n = 0; n < 20; n++) send_pair(rand_pair());
    drain();

    $display("run covered %0d pair beats, four idle/stall mixes, several restitutions",
             beats_sent);
    $display("outcomes seen: %0d impulse, %0d separating, %0d coincident",
             n_impulse, n_separate, n_coincident);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
